[rtl/pgcu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgcu_pkg
// Shared constants, codes and beat types of the periodic grid cubic upsampler.
// ----------------------------------------------------------------------------
package pgcu_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int MAX_FACTOR = 8;

   localparam int ROW_IW     = $clog2(MAX_ROWS);
   localparam int COL_IW     = $clog2(MAX_COLS);
   localparam int ROW_CW     = $clog2(MAX_ROWS + 1);
   localparam int COL_CW     = $clog2(MAX_COLS + 1);
   localparam int FACT_W     = $clog2(MAX_FACTOR + 1);
   localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W     = $clog2(GRID_DEPTH);

   localparam int POS_W  = 9;
   localparam int FRAC_W = 16;
   localparam int DIV_W  = POS_W + FRAC_W;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_INTERP = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_INTERP = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [1:0] REG_ROWS  = 2'd0;
   localparam logic [1:0] REG_COLS  = 2'd1;
   localparam logic [1:0] REG_RFACT = 2'd2;
   localparam logic [1:0] REG_CFACT = 2'd3;

   typedef struct packed {
      logic              cmd;
      logic [8:0]        row;
      logic [8:0]        col;
      logic signed [31:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [6:0] rows_in_use;
      logic [6:0] cols_in_use;
      logic [3:0] row_factor;
      logic [3:0] col_factor;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] waddr;
      logic [31:0]       sample;
      logic [ROW_IW-1:0] rm;
      logic [ROW_IW-1:0] r;
      logic [ROW_IW-1:0] rp;
      logic [ROW_IW-1:0] rpp;
      logic [COL_IW-1:0] cm;
      logic [COL_IW-1:0] c;
      logic [COL_IW-1:0] cp;
      logic [COL_IW-1:0] cpp;
      logic [FRAC_W-1:0] xf;
      logic [FRAC_W-1:0] yf;
   } job_type;

endpackage
`default_nettype wire

[rtl/pgcu_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgcu_front
// Accepts request beats, range-checks them and, for interpolation, divides
// the output position by the factor to get the source cell and Q0.16 fraction.
// ----------------------------------------------------------------------------
module pgcu_front (
   input  logic              clock,
   input  logic              reset,
   input  pgcu_pkg::cfg_type cfg,
   input  logic              hold,
   input  logic              req_valid,
   output logic              req_ready,
   input  pgcu_pkg::req_type req_data,
   output logic              job_valid,
   input  logic              job_ready,
   output pgcu_pkg::job_type job_data
);
   import pgcu_pkg::*;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;
   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [1:0]        state_ff, state_in;
   req_type           item_ff, item_in;
   logic [ROW_CW-1:0] nr_ff, nr_in;
   logic [COL_CW-1:0] nc_ff, nc_in;
   logic [FACT_W-1:0] rf_ff, rf_in, cf_ff, cf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]  rquo_ff, rquo_in, cquo_ff, cquo_in;
   logic [FACT_W-1:0] rrem_ff, rrem_in, crem_ff, crem_in;

   logic [FACT_W:0]   rtry, ctry;
   logic              err_write, err_interp;
   logic [ROW_CW:0]   r_w, rm_w, rp_w, rpp_w, nr_w;
   logic [COL_CW:0]   c_w, cm_w, cp_w, cpp_w, nc_w;

   assign req_ready = (state_ff == F_IDLE) && !hold;
   assign job_valid = (state_ff == F_PUSH);

   always_comb begin
      rtry = {rrem_ff, rquo_ff[DIV_W-1]};
      ctry = {crem_ff, cquo_ff[DIV_W-1]};
   end

   always_comb begin
      err_write  = (16'(item_ff.row) >= 16'(nr_ff)) || (16'(item_ff.col) >= 16'(nc_ff));
      err_interp = (16'(item_ff.row) >= 16'(rf_ff) * 16'(nr_ff)) ||
                   (16'(item_ff.col) >= 16'(cf_ff) * 16'(nc_ff));
   end

   // Neighbor indices wrap around the grid in use.
   always_comb begin
      nr_w  = (ROW_CW+1)'(nr_ff);
      nc_w  = (COL_CW+1)'(nc_ff);
      r_w   = (ROW_CW+1)'(rquo_ff[DIV_W-1:FRAC_W]);
      c_w   = (COL_CW+1)'(cquo_ff[DIV_W-1:FRAC_W]);
      rm_w  = (r_w == '0) ? nr_w - 1'b1 : r_w - 1'b1;
      rp_w  = r_w + 1'b1;
      if (rp_w >= nr_w) rp_w = rp_w - nr_w;
      rpp_w = r_w + 2'd2;
      if (rpp_w >= nr_w) rpp_w = rpp_w - nr_w;
      if (rpp_w >= nr_w) rpp_w = rpp_w - nr_w;
      cm_w  = (c_w == '0) ? nc_w - 1'b1 : c_w - 1'b1;
      cp_w  = c_w + 1'b1;
      if (cp_w >= nc_w) cp_w = cp_w - nc_w;
      cpp_w = c_w + 2'd2;
      if (cpp_w >= nc_w) cpp_w = cpp_w - nc_w;
      if (cpp_w >= nc_w) cpp_w = cpp_w - nc_w;
   end

   always_comb begin
      job_data        = '0;
      job_data.waddr  = ADDR_W'(32'(item_ff.row) * 32'(MAX_COLS) + 32'(item_ff.col));
      job_data.sample = item_ff.sample;
      job_data.rm     = ROW_IW'(rm_w);
      job_data.r      = ROW_IW'(r_w);
      job_data.rp     = ROW_IW'(rp_w);
      job_data.rpp    = ROW_IW'(rpp_w);
      job_data.cm     = COL_IW'(cm_w);
      job_data.c      = COL_IW'(c_w);
      job_data.cp     = COL_IW'(cp_w);
      job_data.cpp    = COL_IW'(cpp_w);
      job_data.xf     = rquo_ff[FRAC_W-1:0];
      job_data.yf     = cquo_ff[FRAC_W-1:0];
      if (item_ff.cmd == CMD_WRITE) begin
         job_data.kind = err_write ? KIND_ERROR : KIND_WRITE;
      end else begin
         job_data.kind = err_interp ? KIND_ERROR : KIND_INTERP;
      end
   end

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      nr_in    = nr_ff;
      nc_in    = nc_ff;
      rf_in    = rf_ff;
      cf_in    = cf_ff;
      cnt_in   = cnt_ff;
      rquo_in  = rquo_ff;
      cquo_in  = cquo_ff;
      rrem_in  = rrem_ff;
      crem_in  = crem_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid && req_ready) begin
               item_in = req_data;
               if (cfg.rows_in_use == '0) nr_in = ROW_CW'(1);
               else if (16'(cfg.rows_in_use) > 16'(MAX_ROWS)) nr_in = ROW_CW'(MAX_ROWS);
               else nr_in = ROW_CW'(cfg.rows_in_use);
               if (cfg.cols_in_use == '0) nc_in = COL_CW'(1);
               else if (16'(cfg.cols_in_use) > 16'(MAX_COLS)) nc_in = COL_CW'(MAX_COLS);
               else nc_in = COL_CW'(cfg.cols_in_use);
               if (cfg.row_factor == '0) rf_in = FACT_W'(1);
               else if (16'(cfg.row_factor) > 16'(MAX_FACTOR)) rf_in = FACT_W'(MAX_FACTOR);
               else rf_in = FACT_W'(cfg.row_factor);
               if (cfg.col_factor == '0) cf_in = FACT_W'(1);
               else if (16'(cfg.col_factor) > 16'(MAX_FACTOR)) cf_in = FACT_W'(MAX_FACTOR);
               else cf_in = FACT_W'(cfg.col_factor);
               cnt_in  = '0;
               rquo_in = {req_data.row, {FRAC_W{1'b0}}};
               cquo_in = {req_data.col, {FRAC_W{1'b0}}};
               rrem_in = '0;
               crem_in = '0;
               state_in = (req_data.cmd == CMD_WRITE) ? F_PUSH : F_DIV;
            end
         end
         F_DIV: begin
            // One quotient bit per beat; the low 16 quotient bits are the fraction.
            if (rtry >= {1'b0, rf_ff}) begin
               rrem_in = FACT_W'(rtry - {1'b0, rf_ff});
               rquo_in = {rquo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rrem_in = FACT_W'(rtry);
               rquo_in = {rquo_ff[DIV_W-2:0], 1'b0};
            end
            if (ctry >= {1'b0, cf_ff}) begin
               crem_in = FACT_W'(ctry - {1'b0, cf_ff});
               cquo_in = {cquo_ff[DIV_W-2:0], 1'b1};
            end else begin
               crem_in = FACT_W'(ctry);
               cquo_in = {cquo_ff[DIV_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1)) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (job_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff <= item_in;
      nr_ff   <= nr_in;
      nc_ff   <= nc_in;
      rf_ff   <= rf_in;
      cf_ff   <= cf_in;
      cnt_ff  <= cnt_in;
      rquo_ff <= rquo_in;
      cquo_ff <= cquo_in;
      rrem_ff <= rrem_in;
      crem_ff <= crem_in;
   end

endmodule
`default_nettype wire

[rtl/pgcu_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgcu_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module pgcu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  pgcu_pkg::job_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output pgcu_pkg::job_type out_data
);
   import pgcu_pkg::*;

   job_type    slot_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wp_in    = push ? ~wp_ff : wp_ff;
      rp_in    = pop ? ~rp_ff : rp_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
      if (push) slot_ff[wp_ff] <= in_data;
   end

endmodule
`default_nettype wire

[rtl/pgcu_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgcu_back
// Owns the grid memory. Stores samples and evaluates the four cubics of an
// interpolation with one shared multiplier, then rounds and saturates.
// ----------------------------------------------------------------------------
module pgcu_back (
   input  logic              clock,
   input  logic              reset,
   output logic              clearing,
   input  logic              job_valid,
   output logic              job_ready,
   input  pgcu_pkg::job_type job_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pgcu_pkg::rsp_type rsp_data
);
   import pgcu_pkg::*;

   localparam logic [3:0] B_CLEAR = 4'd0;
   localparam logic [3:0] B_IDLE  = 4'd1;
   localparam logic [3:0] B_READ  = 4'd2;
   localparam logic [3:0] B_COEF  = 4'd3;
   localparam logic [3:0] B_M1    = 4'd4;
   localparam logic [3:0] B_M2    = 4'd5;
   localparam logic [3:0] B_M3    = 4'd6;
   localparam logic [3:0] B_ACC   = 4'd7;
   localparam logic [3:0] B_ROUND = 4'd8;
   localparam logic [3:0] B_DONE  = 4'd9;

   localparam int COEF_W = 38;
   localparam int T_W    = 40;
   localparam int M_W    = 18;
   localparam int P_W    = T_W + M_W;
   localparam int ACC_W  = 60;
   localparam int Q_W    = ACC_W - 18;

   logic [31:0]       grid_mem [GRID_DEPTH];
   logic [31:0]       rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [31:0]       mem_wd;

   logic [3:0]              state_ff, state_in;
   logic [ADDR_W-1:0]       clr_ff, clr_in;
   job_type                 job_ff, job_in;
   logic [1:0]              k_ff, k_in;
   logic [2:0]              rd_ff, rd_in;
   logic signed [31:0]      p_ff [4];
   logic signed [COEF_W-1:0] b_ff, b_in, c_ff, c_in;
   logic signed [T_W-1:0]   t_ff, t_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   rsp_type                 res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [ROW_IW-1:0]       rd_row;
   logic [COL_IW-1:0]       rd_col;
   logic [ROW_IW-1:0]       rows [4];
   logic [COL_IW-1:0]       cols [4];
   logic [FRAC_W-1:0]       frac;
   logic [FRAC_W:0]         weight;
   logic signed [M_W-1:0]   mul_b;
   logic signed [P_W-1:0]   prod;
   logic signed [COEF_W-1:0] p0, p1, p2, p3, a_coef;
   logic signed [ACC_W-1:0] rnd;
   logic signed [Q_W-1:0]   q;

   assign clearing  = (state_ff == B_CLEAR);
   assign job_ready = (state_ff == B_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      rows[0] = job_ff.rm;
      rows[1] = job_ff.r;
      rows[2] = job_ff.rp;
      rows[3] = job_ff.rpp;
      cols[0] = job_ff.cm;
      cols[1] = job_ff.c;
      cols[2] = job_ff.cp;
      cols[3] = job_ff.cpp;
      // Cubics 0 and 1 run along rows at columns c and c+1, cubics 2 and 3
      // along columns at rows r and r+1.
      unique case (k_ff)
         2'd0: begin rd_row = rows[rd_ff[1:0]]; rd_col = job_ff.c; end
         2'd1: begin rd_row = rows[rd_ff[1:0]]; rd_col = job_ff.cp; end
         2'd2: begin rd_row = job_ff.r; rd_col = cols[rd_ff[1:0]]; end
         default: begin rd_row = job_ff.rp; rd_col = cols[rd_ff[1:0]]; end
      endcase
      frac = k_ff[1] ? job_ff.yf : job_ff.xf;
      unique case (k_ff)
         2'd0: weight = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, job_ff.yf};
         2'd1: weight = {1'b0, job_ff.yf};
         2'd2: weight = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, job_ff.xf};
         default: weight = {1'b0, job_ff.xf};
      endcase
      mul_b = (state_ff == B_ACC) ? $signed(M_W'(weight)) : $signed(M_W'(frac));
      prod  = P_W'(t_ff) * P_W'(mul_b);
   end

   always_comb begin
      p0 = COEF_W'(p_ff[0]);
      p1 = COEF_W'(p_ff[1]);
      p2 = COEF_W'(p_ff[2]);
      p3 = COEF_W'(p_ff[3]);
      a_coef = -p0 + 3 * p1 - 3 * p2 + p3;
      rnd = acc_ff + (ACC_W'(1) <<< 17);
      q   = rnd[ACC_W-1:18];
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = job_data.waddr;
      mem_wd = job_data.sample;
      mem_ra = ADDR_W'(32'(rd_row) * 32'(MAX_COLS) + 32'(rd_col));
      if (state_ff == B_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
         mem_wd = '0;
      end else if (state_ff == B_IDLE && job_valid && job_data.kind == KIND_WRITE) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) grid_mem[mem_wa] <= mem_wd;
      rdata_ff <= grid_mem[mem_ra];
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      job_in       = job_ff;
      k_in         = k_ff;
      rd_in        = rd_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         B_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(GRID_DEPTH - 1)) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (job_valid) begin
               job_in = job_data;
               res_in.result = '0;
               unique case (job_data.kind)
                  KIND_WRITE: begin
                     res_in.status = ST_OK;
                     state_in = B_DONE;
                  end
                  KIND_INTERP: begin
                     acc_in = '0;
                     k_in = 2'd0;
                     rd_in = 3'd0;
                     state_in = B_READ;
                  end
                  default: begin
                     res_in.status = ST_RANGE;
                     state_in = B_DONE;
                  end
               endcase
            end
         end
         B_READ: begin
            // Read data comes through the rdata_ff register behind the address.
            rd_in = rd_ff + 1'b1;
            if (rd_ff == 3'd4) state_in = B_COEF;
         end
         B_COEF: begin
            b_in = 2 * p0 - 5 * p1 + 4 * p2 - p3;
            c_in = p2 - p0;
            t_in = T_W'(a_coef);
            state_in = B_M1;
         end
         B_M1: begin
            t_in = T_W'(prod >>> 16) + T_W'(b_ff);
            state_in = B_M2;
         end
         B_M2: begin
            t_in = T_W'(prod >>> 16) + T_W'(c_ff);
            state_in = B_M3;
         end
         B_M3: begin
            t_in = T_W'(prod >>> 16) + (T_W'(p1) <<< 1);
            state_in = B_ACC;
         end
         B_ACC: begin
            acc_in = acc_ff + ACC_W'(prod);
            k_in = k_ff + 1'b1;
            rd_in = 3'd0;
            state_in = (k_ff == 2'd3) ? B_ROUND : B_READ;
         end
         B_ROUND: begin
            if ((q[Q_W-1:31] == '0) || (q[Q_W-1:31] == '1)) begin
               res_in.result = q[31:0];
               res_in.status = ST_OK;
            end else begin
               res_in.result = q[Q_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               res_in.status = ST_SAT;
            end
            state_in = B_DONE;
         end
         B_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in = res_ff;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff <= job_in;
      k_ff   <= k_in;
      rd_ff  <= rd_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      t_ff   <= t_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      if (state_ff == B_READ && rd_ff != 3'd0) p_ff[2'(rd_ff - 1'b1)] <= rdata_ff;
   end

endmodule
`default_nettype wire

[rtl/periodic_grid_cubic_upsampler.sv]
`default_nettype none
// Write beats skip the front's divider; interpolation beats pass the bit-serial divider,
// then the back evaluates four cubics in turn, where one grid memory port reads 4 samples
// per cubic and one multiplier runs 4 times per cubic.
// The back takes a new job only from idle, so its sequence bounds interpolation throughput.
// Reset is synchronous; afterwards the grid is cleared one entry per cycle, with req_ready
// low. Configuration writes are taken during that time.
// ----------------------------------------------------------------------------
// periodic_grid_cubic_upsampler
// Periodic Catmull-Rom upsampler: front divides and checks, a queue decouples,
// the back reads the grid and evaluates the cubics.
// ----------------------------------------------------------------------------
module periodic_grid_cubic_upsampler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pgcu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pgcu_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import pgcu_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    clearing;
   logic    job_valid, job_ready, back_valid, back_ready;
   job_type job_data, back_data;

   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_ROWS:  cfg_in.rows_in_use = pwdata[6:0];
            REG_COLS:  cfg_in.cols_in_use = pwdata[6:0];
            REG_RFACT: cfg_in.row_factor  = pwdata[3:0];
            default:   cfg_in.col_factor  = pwdata[3:0];
         endcase
      end
      unique case (paddr[3:2])
         REG_ROWS:  prdata = {25'd0, cfg_ff.rows_in_use};
         REG_COLS:  prdata = {25'd0, cfg_ff.cols_in_use};
         REG_RFACT: prdata = {28'd0, cfg_ff.row_factor};
         default:   prdata = {28'd0, cfg_ff.col_factor};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows_in_use <= 7'd64;
         cfg_ff.cols_in_use <= 7'd64;
         cfg_ff.row_factor  <= 4'd1;
         cfg_ff.col_factor  <= 4'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pgcu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .hold      (clearing),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_data  (job_data)
   );

   pgcu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (job_valid),
      .in_ready  (job_ready),
      .in_data   (job_data),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_data)
   );

   pgcu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .job_data  (back_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
